// ----- sv/adns_pkg.sv -----
// adns_pkg: shared types and constants of the ascii decimal number scanner
// no dependencies; imported by the core module and adns_step, not by adns_div10
package adns_pkg;

  // scan phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEK = 2'd1,
    PH_INT  = 2'd2,
    PH_FRAC = 2'd3
  } phase_t;

  // item function codes
  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_BYTE  = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;

  // configuration register indexes
  localparam logic CFG_DECIMAL_MODE  = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;

  localparam logic [30:0] MAG_MAX  = 31'h7fff_ffff;
  localparam logic [15:0] TICK_MAX = 16'hffff;

  typedef struct packed {
    phase_t      phase;
    logic        sign;
    logic [30:0] whole;
    logic [31:0] frac;
    logic [31:0] weight;
    logic [15:0] idle;
  } scan_state_t;

  typedef struct packed {
    logic        decimal_mode;
    logic [15:0] timeout_ticks;
  } scan_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [30:0] magnitude;
    logic [31:0] fraction;
    logic        is_negative;
    logic        ended_by_timeout;
  } scan_res_t;

endpackage

// ----- sv/adns_if.sv -----
// adns_in_if / adns_out_if: valid-ready channels of the scanner
// depends on nothing; payload widths follow the item formats
interface adns_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface adns_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] magnitude;
  logic [31:0] fraction;
  logic        is_negative;
  logic        ended_by_timeout;

  modport source (output valid, output magnitude, output fraction, output is_negative,
                  output ended_by_timeout, input ready);
  modport sink   (input valid, input magnitude, input fraction, input is_negative,
                  input ended_by_timeout, output ready);
endinterface

// ----- sv/ascii_decimal_number_scanner_core.sv -----
// ascii_decimal_number_scanner_core: top level of the ascii decimal number scanner
// depends on adns_pkg, adns_in_if / adns_out_if and adns_step
//
// usage
//   in_ch carries one item per handshake: func 0 arms a scan, func 1 delivers a
//   received byte, func 2 is a millisecond tick. out_ch gives one item per scan
//   that ends: magnitude, 0.32 fraction, sign and a timeout flag
//   cfg_we/cfg_index/cfg_wdata write decimal_mode (index 0) and timeout_ticks
//   (index 1); write only while no item is in flight
// timing
//   an accepted item is held in the input register, then updated into the scan
//   state and result register at the next edge: a result is on out_ch one
//   cycle after its item was accepted and can be taken at the edge after that
//   one item per cycle is sustained; the state update for each item is a single
//   pass through adns_step (shift-add, a 4x32 multiply and a divide by ten)
// reset
//   synchronous, active low: no scan armed, both registers empty, decimal_mode 0,
//   timeout_ticks 1000
// stall
//   when out_ch is held, the result register keeps its item; one more item
//   waits in the input register, then in_ch.ready drops
module ascii_decimal_number_scanner_core
  import adns_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  adns_in_if.sink     in_ch,
  adns_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [31:0] WEIGHT0 = 32'((64'd1 << FRAC_BITS) / 10);

  // input register
  logic        in_vld_r;
  logic [1:0]  in_func_r;
  logic [7:0]  in_byte_r;

  // scan state and configuration
  scan_state_t st_r;
  scan_state_t st_nxt;
  scan_cfg_t   cfg_r;

  // result register
  logic        out_vld_r;
  scan_res_t   res;
  scan_res_t   res_r;

  logic        step_fire;
  logic        in_take;

  // the step runs when the result register can take whatever it produces
  assign step_fire    = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step_fire;
  assign in_take      = in_ch.valid && in_ch.ready;

  adns_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .st      (st_r),
    .cfg     (cfg_r),
    .func    (in_func_r),
    .rx_byte (in_byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_take) begin
      in_func_r <= in_ch.func;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= PH_IDLE;
      st_r.sign   <= 1'b0;
      st_r.whole  <= '0;
      st_r.frac   <= '0;
      st_r.weight <= WEIGHT0;
      st_r.idle   <= '0;
    end else if (step_fire) begin
      st_r <= st_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decimal_mode  <= 1'b0;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECIMAL_MODE:  cfg_r.decimal_mode  <= cfg_wdata[0];
        CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_wdata;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_fire && res.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (step_fire && res.valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.magnitude        = res_r.magnitude;
  assign out_ch.fraction         = res_r.fraction;
  assign out_ch.is_negative      = res_r.is_negative;
  assign out_ch.ended_by_timeout = res_r.ended_by_timeout;

  // a scan that ends leaves nothing armed
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && res.valid) |=> (st_r.phase == PH_IDLE))
    else $error("scan still armed after its result");

  // while seeking nothing has been gathered yet
  a_seek_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_SEEK) |-> (st_r.whole == '0 && st_r.frac == '0 && !st_r.sign))
    else $error("accumulators not clear while seeking");

  // a result never appears without a step behind it
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(step_fire && res.valid))
    else $error("result without a finished scan");

endmodule

// ----- sv/adns_div10.sv -----
// adns_div10: unsigned 32-bit divide by ten via reciprocal multiply
// no package use; instantiated by adns_step
module adns_div10 (
  input  logic [31:0] dividend,
  output logic [31:0] quotient
);

  logic [63:0] prod;

  // ceil(2^35/10), exact for every 32-bit dividend
  assign prod     = 64'(dividend) * 64'(32'hcccc_cccd);
  assign quotient = {3'b000, prod[63:35]};

endmodule

// ----- sv/adns_step.sv -----
// adns_step: next scan state and result for one item
// depends on adns_pkg and adns_div10
module adns_step
  import adns_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  scan_state_t st,
  input  scan_cfg_t   cfg,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  output scan_state_t st_nxt,
  output scan_res_t   res
);

  localparam logic [32:0] FRAC_MAX = 33'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [31:0] WEIGHT0  = 32'((64'd1 << FRAC_BITS) / 10);

  logic        is_digit;
  logic        point_ok;
  logic [3:0]  digit;
  logic [34:0] int_sum;
  logic [30:0] int_sat;
  logic [35:0] frac_prod;
  logic [36:0] frac_sum;
  logic [31:0] frac_sat;
  logic [31:0] weight_div;
  logic [15:0] idle_inc;
  logic        timed_out;
  logic        byte_ends;
  phase_t      phase_nxt;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign point_ok  = (rx_byte == CH_POINT) && cfg.decimal_mode;
  assign digit     = 4'(rx_byte - CH_ZERO);

  // whole * 10 + digit as shift-add
  assign int_sum   = {st.whole, 4'b0000} - {3'b000, st.whole, 1'b0} - {2'b00, st.whole, 2'b00}
                     + 35'(digit);
  assign int_sat   = (int_sum > 35'(MAG_MAX)) ? MAG_MAX : int_sum[30:0];

  assign frac_prod = 36'(digit) * 36'(st.weight);
  assign frac_sum  = 37'(st.frac) + 37'(frac_prod);
  assign frac_sat  = (frac_sum > 37'(FRAC_MAX)) ? FRAC_MAX[31:0] : frac_sum[31:0];

  adns_div10 u_div10 (
    .dividend (st.weight),
    .quotient (weight_div)
  );

  assign idle_inc  = (st.idle != TICK_MAX) ? st.idle + 16'd1 : st.idle;
  assign timed_out = (idle_inc >= cfg.timeout_ticks);

  // a byte that does not continue the number in the digit phases
  always_comb begin
    case (st.phase)
      PH_INT:  byte_ends = !is_digit && !point_ok;
      PH_FRAC: byte_ends = !is_digit;
      default: byte_ends = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = st.phase;
    if (func == FN_START) begin
      phase_nxt = PH_SEEK;
    end else if (st.phase != PH_IDLE) begin
      if (func == FN_TICK) begin
        if (timed_out) phase_nxt = PH_IDLE;
      end else if (func == FN_BYTE) begin
        case (st.phase)
          PH_SEEK: begin
            if (is_digit || rx_byte == CH_MINUS) phase_nxt = PH_INT;
            else if (point_ok)                   phase_nxt = PH_FRAC;
          end
          PH_INT: begin
            if (point_ok)       phase_nxt = PH_FRAC;
            else if (byte_ends) phase_nxt = PH_IDLE;
          end
          PH_FRAC: begin
            if (byte_ends) phase_nxt = PH_IDLE;
          end
          default: phase_nxt = st.phase;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    st_nxt       = st;
    st_nxt.phase = phase_nxt;
    res.valid            = 1'b0;
    res.magnitude        = st.whole;
    res.fraction         = st.frac;
    res.is_negative      = st.sign;
    res.ended_by_timeout = 1'b0;
    if (func == FN_START) begin
      st_nxt.sign   = 1'b0;
      st_nxt.whole  = '0;
      st_nxt.frac   = '0;
      st_nxt.weight = WEIGHT0;
      st_nxt.idle   = '0;
    end else if (st.phase != PH_IDLE) begin
      if (func == FN_TICK) begin
        st_nxt.idle = idle_inc;
        if (timed_out) begin
          res.valid            = 1'b1;
          res.ended_by_timeout = 1'b1;
        end
      end else if (func == FN_BYTE) begin
        st_nxt.idle = '0;
        if (st.phase == PH_SEEK && rx_byte == CH_MINUS) st_nxt.sign = 1'b1;
        if ((st.phase == PH_SEEK || st.phase == PH_INT) && is_digit) st_nxt.whole = int_sat;
        if (st.phase == PH_FRAC && is_digit) begin
          st_nxt.frac   = frac_sat;
          st_nxt.weight = weight_div;
        end
        res.valid = byte_ends;
      end
    end
  end

endmodule

// ----- sim/tb.sv -----
// tb: self-checking bench for ascii_decimal_number_scanner_core, driving bytes, ticks and starts
// depends on adns_pkg, the adns_in_if / adns_out_if channels and the core with adns_step and adns_div10
// a directed table comes first, then random scans; results are checked against a predictor or hand-typed values
module tb
  import adns_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // func code that the block has no use for
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_LETTER  = 8'h78;
  localparam logic [31:0] WEIGHT_TOP = 32'd429496729;   // floor(2^32 / 10)
  localparam logic [31:0] FRAC_TOP   = 32'hffff_ffff;

  localparam int ITEM_TARGET    = 950;
  localparam int RETUNE_EVERY   = 80;
  localparam int SQUEEZE_AT     = 400;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 500000;

  // one number as it leaves the block
  typedef struct packed {
    logic [30:0] magnitude;
    logic [31:0] fraction;
    logic        is_negative;
    logic        ended_by_timeout;
  } number_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed table: an item, or a register write
  typedef struct {
    row_kind_t   kind;
    logic [1:0]  func;
    logic [7:0]  data;
    logic        reg_sel;
    logic [15:0] reg_val;
    bit          has_lit;
    number_t     lit;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  adns_in_if  in_ch ();
  adns_out_if out_ch ();

  ascii_decimal_number_scanner_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the scanner: registers and scan state
  logic        sc_decimal;
  logic [15:0] sc_timeout;
  phase_t      sc_phase;
  logic        sc_sign;
  logic [30:0] sc_whole;
  logic [31:0] sc_frac;
  logic [31:0] sc_weight;
  logic [15:0] sc_idle;

  number_t   numbers_due[$];   // numbers still owed by the block, oldest first
  plan_row_t plan[$];

  int mismatches  = 0;
  int items_done  = 0;   // items that the block acted on
  int cycle_count = 0;
  bit send_calm   = 0;
  bit recv_calm   = 0;
  bit squeeze_req = 0;
  bit squeeze_done = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------- helpers

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic plan_row_t mk_item(logic [1:0] f, logic [7:0] b);
    plan_row_t row;
    row = '{kind: ROW_ITEM, func: f, data: b, reg_sel: 1'b0, reg_val: '0,
            has_lit: 1'b0, lit: '0};
    return row;
  endfunction

  // item whose result is typed in by hand
  function automatic plan_row_t mk_lit(logic [1:0] f, logic [7:0] b, logic [30:0] mag,
                                       logic [31:0] frac, logic neg, logic tmo);
    plan_row_t row;
    row = mk_item(f, b);
    row.has_lit = 1'b1;
    row.lit = '{mag, frac, neg, tmo};
    return row;
  endfunction

  function automatic plan_row_t mk_cfg(logic sel, logic [15:0] val);
    plan_row_t row;
    row = mk_item(FN_START, 8'h00);
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic number_t close_scan(logic tmo);
    sc_phase = PH_IDLE;
    return '{sc_whole, sc_frac, sc_sign, tmo};
  endfunction

  // times ten plus digit with a sticky ceiling at 2^31-1
  function automatic void add_whole_digit(logic [3:0] d);
    logic [63:0] v;
    v = 64'(sc_whole) * 64'd10 + 64'(d);
    sc_whole = (v > 64'(MAG_MAX)) ? MAG_MAX : v[30:0];
  endfunction

  // advance the scan by one item; acted is low when the block ignores the item
  task automatic predict_scan(input logic [1:0] f, input logic [7:0] b,
                              output bit acted, output bit produced, output number_t res);
    logic        is_digit;
    logic        point_ok;
    logic [63:0] v;
    acted    = 1'b1;
    produced = 1'b0;
    res      = '0;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    point_ok = (b == CH_POINT) && sc_decimal;
    if (f == FN_START) begin
      sc_phase  = PH_SEEK;
      sc_sign   = 1'b0;
      sc_whole  = '0;
      sc_frac   = '0;
      sc_weight = WEIGHT_TOP;
      sc_idle   = '0;
    end else if (sc_phase == PH_IDLE || f == FN_UNUSED) begin
      acted = 1'b0;
    end else if (f == FN_TICK) begin
      if (sc_idle != TICK_MAX) sc_idle = sc_idle + 16'd1;
      if (sc_idle >= sc_timeout) begin
        res = close_scan(1'b1);
        produced = 1'b1;
      end
    end else begin
      sc_idle = '0;
      case (sc_phase)
        PH_SEEK: begin
          if (is_digit) begin
            add_whole_digit(b[3:0]);
            sc_phase = PH_INT;
          end else if (b == CH_MINUS) begin
            sc_sign  = 1'b1;
            sc_phase = PH_INT;
          end else if (point_ok) begin
            sc_phase = PH_FRAC;
          end
        end
        PH_INT: begin
          if (is_digit) add_whole_digit(b[3:0]);
          else if (point_ok) sc_phase = PH_FRAC;
          else begin
            res = close_scan(1'b0);
            produced = 1'b1;
          end
        end
        default: begin
          if (is_digit) begin
            v = 64'(sc_frac) + 64'(b[3:0]) * 64'(sc_weight);
            sc_frac   = (v > 64'(FRAC_TOP)) ? FRAC_TOP : v[31:0];
            sc_weight = sc_weight / 32'd10;
          end else begin
            res = close_scan(1'b0);
            produced = 1'b1;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- driving

  // offer one item after a random gap, hold it until accepted, then predict
  task automatic offer_item(input logic [1:0] f, input logic [7:0] b,
                            input bit has_lit, input number_t lit);
    int      gap;
    bit      acted;
    bit      produced;
    number_t res;
    gap = pick_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.func    = f;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    predict_scan(f, b, acted, produced, res);
    // a hand-typed result stands in for the predicted one
    if (has_lit) numbers_due.push_back(lit);
    else if (produced) numbers_due.push_back(res);
    if (acted) items_done++;
  endtask

  task automatic offer(input logic [1:0] f, input logic [7:0] b);
    offer_item(f, b, 1'b0, '0);
  endtask

  // wait until nothing is owed, plus the pipeline depth for silent items
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (numbers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input logic sel, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == CFG_DECIMAL_MODE) sc_decimal = val[0];
    else sc_timeout = val;
  endtask

  // sometimes a tick or two between bytes
  task automatic stray_ticks();
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 2)) offer(FN_TICK, 8'($urandom));
  endtask

  // start, junk, optional sign, digits, optional point and fraction, terminator
  task automatic well_formed_scan();
    int         n;
    logic [7:0] c;
    offer(FN_START, 8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      offer(FN_BYTE, 8'($urandom));
      stray_ticks();
    end
    if ($urandom_range(0, 2) == 0) offer(FN_BYTE, CH_MINUS);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
    repeat (n) begin
      offer(FN_BYTE, 8'(CH_ZERO + $urandom_range(0, 9)));
      stray_ticks();
    end
    if ($urandom_range(0, 1) == 0) begin
      offer(FN_BYTE, CH_POINT);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 5);
      repeat (n) begin
        offer(FN_BYTE, 8'(CH_ZERO + $urandom_range(0, 9)));
        stray_ticks();
      end
    end
    // the odd restart part way through
    if ($urandom_range(0, 19) == 0) offer(FN_START, 8'($urandom));
    if (sc_timeout <= 16'd8 && $urandom_range(0, 2) == 0) begin
      repeat (int'(sc_timeout) + 1) offer(FN_TICK, 8'($urandom));
    end else begin
      c = 8'($urandom);
      if (c >= CH_ZERO && c <= CH_NINE) c = CH_SPACE;
      offer(FN_BYTE, c);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // every accepted result against the oldest number owed
  always @(posedge clk) begin : check_results
    number_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (numbers_due.size() == 0) begin
        report_mismatch("result with nothing due", {1'b0, out_ch.magnitude}, '0);
      end else begin
        want = numbers_due.pop_front();
        if (out_ch.magnitude !== want.magnitude)
          report_mismatch("magnitude", {1'b0, out_ch.magnitude}, {1'b0, want.magnitude});
        if (out_ch.fraction !== want.fraction)
          report_mismatch("fraction", out_ch.fraction, want.fraction);
        if (out_ch.is_negative !== want.is_negative)
          report_mismatch("is_negative", 32'(out_ch.is_negative), 32'(want.is_negative));
        if (out_ch.ended_by_timeout !== want.ended_by_timeout)
          report_mismatch("ended_by_timeout", 32'(out_ch.ended_by_timeout),
                          32'(want.ended_by_timeout));
      end
    end
  end

  // watchdog: a hung block or a missing result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stalls on the result side, plus one long hold-off so the input backs up
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_ch.ready = 1'b0;
        squeeze_done = 1'b1;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
      end else begin
        stall = pick_gap(recv_calm);
        if (stall > 0) begin
          out_ch.ready = 1'b0;
          repeat (stall - 1) @(negedge clk);
        end else begin
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int          next_retune;
    logic [15:0] tmo;
    in_ch.valid   = 1'b0;
    in_ch.func    = FN_START;
    in_ch.rx_byte = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DECIMAL_MODE;
    cfg_wdata     = '0;
    rst_n         = 1'b0;

    // predictor out of reset
    sc_decimal = 1'b0;
    sc_timeout = TIMEOUT_RESET;
    sc_phase   = PH_IDLE;
    sc_sign    = 1'b0;
    sc_whole   = '0;
    sc_frac    = '0;
    sc_weight  = WEIGHT_TOP;
    sc_idle    = '0;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: integer mode, long timeout
    // negative number ended by a letter
    plan.push_back(mk_item(FN_START, 8'h00));
    plan.push_back(mk_item(FN_BYTE, CH_MINUS));
    plan.push_back(mk_item(FN_BYTE, 8'(CH_ZERO + 4)));
    plan.push_back(mk_item(FN_BYTE, 8'(CH_ZERO + 2)));
    plan.push_back(mk_lit(FN_BYTE, CH_LETTER, 31'd42, 32'd0, 1'b1, 1'b0));
    // idle activity and the unused code are ignored
    plan.push_back(mk_item(FN_BYTE, 8'h00));
    plan.push_back(mk_item(FN_TICK, 8'hff));
    plan.push_back(mk_item(FN_UNUSED, 8'hff));
    // junk skipped while seeking, a point skipped in integer mode, then ends it
    plan.push_back(mk_item(FN_START, 8'hff));
    plan.push_back(mk_item(FN_BYTE, 8'hff));
    plan.push_back(mk_item(FN_BYTE, CH_POINT));
    plan.push_back(mk_item(FN_BYTE, 8'(CH_ZERO + 5)));
    plan.push_back(mk_lit(FN_BYTE, CH_POINT, 31'd5, 32'd0, 1'b0, 1'b0));
    // zero timeout: first tick while seeking ends the scan
    plan.push_back(mk_cfg(CFG_DECIMAL_MODE, 16'd1));
    plan.push_back(mk_cfg(CFG_TIMEOUT_TICKS, 16'd0));
    plan.push_back(mk_item(FN_START, 8'h00));
    plan.push_back(mk_lit(FN_TICK, 8'h00, 31'd0, 32'd0, 1'b0, 1'b1));
    // point first in decimal mode: .5 ended by a minus
    plan.push_back(mk_cfg(CFG_TIMEOUT_TICKS, 16'hffff));
    plan.push_back(mk_item(FN_START, 8'h00));
    plan.push_back(mk_item(FN_BYTE, CH_POINT));
    plan.push_back(mk_item(FN_BYTE, 8'(CH_ZERO + 5)));
    plan.push_back(mk_lit(FN_BYTE, CH_MINUS, 31'd0, 32'd2147483645, 1'b0, 1'b0));
    // restart while armed, then a second minus ends the number
    plan.push_back(mk_item(FN_START, 8'h00));
    plan.push_back(mk_item(FN_BYTE, 8'(CH_ZERO + 3)));
    plan.push_back(mk_item(FN_START, 8'h00));
    plan.push_back(mk_item(FN_BYTE, CH_MINUS));
    plan.push_back(mk_lit(FN_BYTE, CH_MINUS, 31'd0, 32'd0, 1'b1, 1'b0));
    // short timeout back in integer mode
    plan.push_back(mk_cfg(CFG_TIMEOUT_TICKS, 16'd2));
    plan.push_back(mk_cfg(CFG_DECIMAL_MODE, 16'd0));
    plan.push_back(mk_item(FN_START, 8'h00));
    plan.push_back(mk_item(FN_TICK, 8'h00));
    plan.push_back(mk_lit(FN_TICK, 8'h00, 31'd0, 32'd0, 1'b0, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        set_register(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        offer_item(plan[i].func, plan[i].data, plan[i].has_lit, plan[i].lit);
      end
    end

    // random part: phases of well-formed scans with some noise, retuned now and then
    next_retune = 0;
    while (items_done < ITEM_TARGET) begin
      if (items_done >= next_retune) begin
        settle();
        case ($urandom_range(0, 5))
          0:       tmo = 16'd0;
          1:       tmo = 16'hffff;
          2:       tmo = 16'($urandom);
          default: tmo = 16'($urandom_range(1, 6));
        endcase
        set_register(CFG_DECIMAL_MODE, 16'($urandom_range(0, 1)));
        set_register(CFG_TIMEOUT_TICKS, tmo);
        send_calm   = ($urandom_range(0, 3) == 0);
        recv_calm   = ($urandom_range(0, 3) == 0);
        next_retune = items_done + RETUNE_EVERY;
      end
      if (items_done >= SQUEEZE_AT) squeeze_req = 1'b1;
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) offer(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        well_formed_scan();
      end
    end

    // drain, then wait for anything still inside
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (numbers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
